/* sv/dis_pkg.sv */
`default_nettype none
package dis_pkg;

	// Width of one element and of a sorted result.
	localparam int unsigned VALUE_W = 32;

	// Default storage depth; a set that fills it is closed automatically.
	localparam int unsigned MAX_ITEMS_DEF = 64;

endpackage
`default_nettype wire

/* sv/descending_integer_sort.sv */
// Descending integer sort.
// Elements arrive one per transaction on the input channel (value, last_in, in_valid,
// in_stall). A transaction with last_in set, or one that fills the last of MAX_ITEMS
// entries, closes the set. The block then stalls its input, sorts the set in place
// in a single-port-write, single-port-read memory with an exchange sort, and emits
// the elements largest first on the output channel (sorted_value, last_out,
// out_valid, out_stall), with last_out set on the final, smallest element.
// Each sort pass for position p steps through S_FETCH, S_PRIME, S_SCAN and S_WB,
// with one compare per cycle in S_SCAN while the running maximum sits in a register.
// While a result is offered, the memory read for the next one is already issued.
// A stalled result holds its value until taken.
// The input channel is stalled from the closing transaction until the last
// result has been taken. Reset clears the element count and the control state;
// the memory contents are not cleared, and no entry's data is used before it is written.
`default_nettype none
module descending_integer_sort #(
	parameter int unsigned MAX_ITEMS = dis_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [dis_pkg::VALUE_W-1:0]   value,
	input  wire logic                                 last_in,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [dis_pkg::VALUE_W-1:0]        sorted_value,
	output logic                                      last_out
);

	localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		S_LOAD,   // accepting elements
		S_FETCH,  // read the entry at the pass position
		S_PRIME,  // take it as the running maximum, read the first later entry
		S_SCAN,   // compare one later entry per cycle, swap when it is larger
		S_WB,     // write the running maximum back to the pass position
		S_ERD,    // read the next result
		S_EWAIT,  // read data arrives and goes to the output register
		S_EOUT    // result offered until the receiver takes it
	} state_t;

	state_t state_q;

	// The element store: written at one address, read at one, read data registered.
	logic signed [dis_pkg::VALUE_W-1:0] mem [MAX_ITEMS];
	logic signed [dis_pkg::VALUE_W-1:0] rd_data_q;

	logic [CNT_W-1:0] count_q;  // elements loaded, then the set size during sort/emit
	logic [CNT_W-1:0] p_q;      // pass position
	logic [CNT_W-1:0] q_q;      // entry whose read data is present in S_SCAN
	logic [CNT_W-1:0] k_q;      // result position during emit
	logic signed [dis_pkg::VALUE_W-1:0] cur_q;  // running maximum of the current pass

	logic [CNT_W-1:0] rd_addr;
	logic [CNT_W-1:0] wr_addr;
	logic             wr_en;
	logic signed [dis_pkg::VALUE_W-1:0] wr_data;

	logic             in_accept;
	logic             out_accept;
	logic [CNT_W-1:0] cnt_next;
	logic             closing;
	logic             swap;
	logic             scan_more;

	assign in_stall   = (state_q != S_LOAD);
	assign in_accept  = in_valid && !in_stall;
	assign out_accept = out_valid && !out_stall;
	assign cnt_next   = count_q + CNT_W'(1);
	assign closing    = last_in || (cnt_next == CNT_W'(MAX_ITEMS));
	assign swap       = (cur_q < rd_data_q);
	assign scan_more  = ((q_q + CNT_W'(1)) < count_q);

	// Memory port control.
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = count_q;
		wr_data = value;
		unique case (state_q)
			S_LOAD: begin
				wr_en = in_accept;
			end
			S_FETCH: begin
				rd_addr = p_q;
			end
			S_PRIME: begin
				rd_addr = p_q + CNT_W'(1);
			end
			S_SCAN: begin
				rd_addr = q_q + CNT_W'(1);
				wr_en   = swap;
				wr_addr = q_q;
				wr_data = cur_q;
			end
			S_WB: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				wr_data = cur_q;
			end
			S_ERD: begin
				rd_addr = k_q;
			end
			S_EOUT: begin
				// On the final result the address lies past the set; that read is unused.
				rd_addr = k_q + CNT_W'(1);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IDX_W-1:0]] <= wr_data;
		end
		rd_data_q <= mem[rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			p_q          <= '0;
			q_q          <= '0;
			k_q          <= '0;
			cur_q        <= '0;
			out_valid    <= 1'b0;
			sorted_value <= '0;
			last_out     <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_accept) begin
						count_q <= cnt_next;
						p_q     <= '0;
						k_q     <= '0;
						if (closing) begin
							// A single element needs no sort.
							state_q <= (cnt_next == CNT_W'(1)) ? S_ERD : S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_PRIME;
				end
				S_PRIME: begin
					cur_q   <= rd_data_q;
					q_q     <= p_q + CNT_W'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// The later entry takes the old maximum, the maximum takes it.
					if (swap) begin
						cur_q <= rd_data_q;
					end
					if (scan_more) begin
						q_q <= q_q + CNT_W'(1);
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if ((p_q + CNT_W'(2)) < count_q) begin
						p_q     <= p_q + CNT_W'(1);
						state_q <= S_FETCH;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					out_valid    <= 1'b1;
					sorted_value <= rd_data_q;
					last_out     <= ((k_q + CNT_W'(1)) == count_q);
					state_q      <= S_EOUT;
				end
				S_EOUT: begin
					if (out_accept) begin
						out_valid <= 1'b0;
						if (last_out) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_EWAIT;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/dis_checker.sv */
`default_nettype none
module dis_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               last_in,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic signed [dis_pkg::VALUE_W-1:0] sorted_value,
	input wire logic                               last_out
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(last_out))
		else $error("stalled result changed");

	// No element is taken while results are being offered.
	a_no_load_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while emitting");

	// A closing transaction shuts the input for the sort.
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_in |=> in_stall)
		else $error("input open after closing transaction");

	// Once the final result is taken, no further result follows at once and input reopens.
	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_out |=> !out_valid && !in_stall)
		else $error("set not finished after last result");

endmodule

bind descending_integer_sort dis_checker u_dis_checker (.*);
`default_nettype wire

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUE_W = dis_pkg::VALUE_W;
	localparam int unsigned SET_DEPTH = dis_pkg::MAX_ITEMS_DEF;
	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	// Sorting a full set accepts nothing on either side; this limit leaves plenty
	// of margin for it.
	localparam int unsigned IDLE_LIMIT = 20000;
	// Roughly how many items the whole stimulus should hold, directed sets included.
	localparam int RANDOM_ITEMS = 130;
	// Cycles to watch for stray results after the last expected one has arrived.
	localparam int SETTLE_CYCLES = 40;

	localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

	// One element waiting to be sent. lead_gap is the number of idle cycles before
	// it is presented. drain holds it back until every pending result has arrived.
	typedef struct {
		logic signed [VALUE_W-1:0] elem;
		logic                      closes;
		int unsigned               lead_gap;
		bit                        drain;
	} feed_item_t;

	// One expected result.
	typedef struct {
		logic signed [VALUE_W-1:0] elem;
		logic                      final_one;
	} sorted_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      last_in = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      last_out;

	descending_integer_sort #(
		.MAX_ITEMS(SET_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_value(sorted_value),
		.last_out(last_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus built by the initial block and used up by the driver.
	feed_item_t feed_queue[$];
	bit         feed_calm = 1'b1;
	bit         feed_drain_next = 1'b0;

	// The elements of the set loaded so far, and the results still due from the block.
	logic signed [VALUE_W-1:0] held_set[$];
	sorted_result_t            sorted_due[$];

	// The accept counters are written on the rising edge and read on the falling edge.
	int unsigned in_issue_count = 0;
	int unsigned in_accept_count = 0;
	int unsigned out_accept_count = 0;
	int unsigned out_seen_count = 0;
	int unsigned errors = 0;

	feed_item_t                head;
	sorted_result_t            due;
	logic signed [VALUE_W-1:0] swap_tmp;
	int unsigned               feed_wait = 0;
	int unsigned               out_hold = 0;
	bit                        out_calm = 1'b0;
	int unsigned               progress_mark = 0;
	int unsigned               idle_cycles = 0;

	task automatic add_element(input logic signed [VALUE_W-1:0] elem, input logic closes);
		feed_item_t item;
		item.elem = elem;
		item.closes = closes;
		item.lead_gap = feed_calm ? 0 : $urandom_range(0, 14);
		item.drain = feed_drain_next;
		feed_drain_next = 1'b0;
		feed_queue.push_back(item);
	endtask

	// Values are mostly fully random. Some are near zero, so that sets hold
	// duplicates, and some are near the two extremes.
	function automatic logic signed [VALUE_W-1:0] draw_element();
		case ($urandom_range(0, 5))
			0: begin
				return VALUE_W'($urandom_range(0, 8) - 4);
			end
			1: begin
				if ($urandom_range(0, 1) == 1)
					return INT_MAX - VALUE_W'($urandom_range(0, 2));
				return INT_MIN + VALUE_W'($urandom_range(0, 2));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// Input driver. A new element is presented only after the previous transaction
	// has gone through. The lead gap and the optional drain are applied before the
	// element shows up on the port, so valid never reacts to stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_accept_count == in_issue_count) begin
			if (feed_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (feed_wait < feed_queue[0].lead_gap) begin
				in_valid <= 1'b0;
				feed_wait++;
			end else if (feed_queue[0].drain && sorted_due.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				head = feed_queue.pop_front();
				value <= head.elem;
				last_in <= head.closes;
				in_valid <= 1'b1;
				in_issue_count++;
				feed_wait = 0;
			end
		end
	end

	// Output stall. After each result is taken, a new random hold time is drawn.
	// Now and then the receiver switches into a calm stretch with no stalls.
	always @(negedge clk) begin
		if (out_accept_count != out_seen_count) begin
			out_seen_count = out_accept_count;
			if ($urandom_range(0, 19) == 0)
				out_calm = !out_calm;
			out_hold = out_calm ? 0 : $urandom_range(0, 14);
		end
		out_stall <= (out_hold != 0);
		if (out_hold != 0)
			out_hold--;
	end

	// Prediction and checking happen on the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			in_accept_count++;
			held_set.push_back(value);
			// A set closes on last_in, or on the element that fills the storage.
			if (last_in || held_set.size() == SET_DEPTH) begin
				// Exchange sort: each position is compared with every later one, and
				// the two are swapped when the later value is strictly larger.
				for (int p = 0; p + 1 < held_set.size(); p++) begin
					for (int q = p + 1; q < held_set.size(); q++) begin
						if (held_set[q] > held_set[p]) begin
							swap_tmp = held_set[p];
							held_set[p] = held_set[q];
							held_set[q] = swap_tmp;
						end
					end
				end
				foreach (held_set[k])
					sorted_due.push_back('{held_set[k], k == held_set.size() - 1});
				held_set.delete();
			end
		end

		if (arst_n && out_valid && !out_stall) begin
			out_accept_count++;
			if (sorted_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, sorted_value %0d, last_out %b",
					$time, sorted_value, last_out);
			end else begin
				due = sorted_due.pop_front();
				if (sorted_value !== due.elem) begin
					errors++;
					$display("%0t: sorted_value expected %0d, got %0d",
						$time, due.elem, sorted_value);
				end
				if (last_out !== due.final_one) begin
					errors++;
					$display("%0t: last_out expected %b, got %b",
						$time, due.final_one, last_out);
				end
			end
		end
	end

	// Watchdog. It counts cycles in which no transaction happens on either channel.
	always @(negedge clk) begin
		if (in_accept_count + out_accept_count != progress_mark) begin
			progress_mark = in_accept_count + out_accept_count;
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int random_count;
		int set_index;
		int set_size;

		// Directed sets. They are sent without gaps so that sets go back to back.
		feed_calm = 1'b1;
		// Single-element sets, at zero and at both extremes.
		add_element(0, 1'b1);
		add_element(INT_MAX, 1'b1);
		add_element(INT_MIN, 1'b1);
		// Mixed signs with both extremes. This checks a signed compare. The first
		// element waits until the single-element sets have drained.
		feed_drain_next = 1'b1;
		add_element(1, 1'b0);
		add_element(INT_MIN, 1'b0);
		add_element(-1, 1'b0);
		add_element(INT_MAX, 1'b0);
		add_element(0, 1'b1);
		// Equal values, which are never swapped.
		add_element(7, 1'b0);
		add_element(-3, 1'b0);
		add_element(7, 1'b0);
		add_element(-3, 1'b0);
		add_element(7, 1'b1);
		// Ascending input is the worst case for swaps. Input that is already
		// descending needs no swaps.
		add_element(-2, 1'b0);
		add_element(-1, 1'b0);
		add_element(0, 1'b0);
		add_element(1, 1'b0);
		add_element(2, 1'b1);
		add_element(2, 1'b0);
		add_element(-2, 1'b1);

		// Random sets, mostly small. One full-depth set is added that never sets
		// last_in and closes by filling the storage.
		random_count = feed_queue.size();
		set_index = 0;
		while (random_count < RANDOM_ITEMS) begin
			feed_calm = ($urandom_range(0, 3) == 0);
			feed_drain_next = ($urandom_range(0, 7) == 0);
			if (set_index == 3)
				set_size = SET_DEPTH;
			else if ($urandom_range(0, 5) == 0)
				set_size = $urandom_range(7, 20);
			else
				set_size = $urandom_range(1, 6);
			for (int k = 0; k < set_size; k++)
				add_element(draw_element(), k == set_size - 1 && set_index != 3);
			random_count += set_size;
			set_index++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every element has been taken and every expected result has arrived.
		// Then leave time for any stray result to show up.
		while (feed_queue.size() != 0 || in_accept_count != in_issue_count ||
				sorted_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
